// ----- design/semi_lagrangian_advection_unit_assert.svh -----
// Assertion macros shared by the advection unit RTL.
`ifndef SEMI_LAGRANGIAN_ADVECTION_UNIT_ASSERT_SVH
`define SEMI_LAGRANGIAN_ADVECTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sla assertion failed");

// Next-cycle implication, disabled during reset.
`define SLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sla assertion failed");

`endif

// ----- design/sla_pkg.sv -----
// Shared constants and types of the semi-Lagrangian advection unit.
`default_nettype none
package sla_pkg;
    localparam int GRID_N_DEFAULT = 64;
    localparam int VAL_W          = 32;
    localparam int FRAC_W         = 16;
    localparam logic [31:0] TIME_STEP_RESET = 32'd6554;

    // Item kind carried in tuser
    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_ADVECT = 1'b1
    } t_kind;
endpackage
`default_nettype wire

// ----- design/sla_bank.sv -----
// One parity bank of the source grid: one write port, one registered read port.
`default_nettype none
module sla_bank
    import sla_pkg::*;
#(
    parameter int AW    = 11,
    parameter int DEPTH = 1089
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [VAL_W-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [VAL_W-1:0] o_rd_data
);
    logic [VAL_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- design/semi_lagrangian_advection_unit.sv -----
// Pipeline: 8 register stages.
// Throughput: one item per cycle while m_axis_tready does not stall the output; four
// parity-banked grid reads and the multiplier stages each take one item per cycle.
// Loads and advect items outside the interior give no result.
// Reset (i_rst_n low, synchronous) clears all stage valids and sets time_step
// to 6554; grid cells are undefined until loaded.
`default_nettype none
`include "semi_lagrangian_advection_unit_assert.svh"
module semi_lagrangian_advection_unit
    import sla_pkg::*;
#(
    parameter int GRID_N = GRID_N_DEFAULT,
    localparam int CW    = $clog2(GRID_N + 2),
    localparam int TDW_I = ((2 * CW + 3 * VAL_W + 7) / 8) * 8,
    localparam int TDW_O = ((2 * CW + VAL_W + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration: time_step
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [31:0]      i_cfg_data,
    // input stream
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [TDW_I-1:0] s_axis_tdata,  // col, row, cell_value, vel_x, vel_y
    input  wire logic             s_axis_tuser,  // kind
    // result stream
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [TDW_O-1:0] m_axis_tdata   // out_col, out_row, advected_value
);
    localparam int NW    = $clog2(GRID_N + 1);
    localparam int DW    = CW + FRAC_W;
    localparam int PW    = CW + 32;
    localparam int MW    = PW + NW;
    localparam int HALF  = (GRID_N + 3) / 2;
    localparam int DEPTH = HALF * HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = 2 * FRAC_W + 1;
    localparam logic [DW-1:0] X_LO = {CW'(0), 1'b1, (FRAC_W-1)'(0)};
    localparam logic [DW-1:0] X_HI = {CW'(GRID_N), 1'b1, (FRAC_W-1)'(0)};
    localparam logic [FRAC_W:0] ONE_Q = {1'b1, FRAC_W'(0)};

    // configuration register
    logic [31:0] r_time_step;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
        end else if (i_cfg_valid) begin
            r_time_step <= i_cfg_data;
        end
    end

    // stage valids and enables
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic en1, en2, en3, en4, en5, en6, en7, en8;
    assign en8 = !r8_v || m_axis_tready;
    assign en7 = !r7_v || en8;
    assign en6 = !r6_v || en7;
    assign en5 = !r5_v || en6;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign s_axis_tready = en1;

    // input unpack
    logic [CW-1:0]    in_col, in_row;
    logic [VAL_W-1:0] in_val, in_vx, in_vy;
    t_kind            in_kind;
    logic             in_ok;
    assign in_col  = s_axis_tdata[CW-1:0];
    assign in_row  = s_axis_tdata[2*CW-1:CW];
    assign in_val  = s_axis_tdata[2*CW+VAL_W-1:2*CW];
    assign in_vx   = s_axis_tdata[2*CW+2*VAL_W-1:2*CW+VAL_W];
    assign in_vy   = s_axis_tdata[2*CW+3*VAL_W-1:2*CW+2*VAL_W];
    assign in_kind = t_kind'(s_axis_tuser);
    always_comb begin
        if (in_kind == KIND_LOAD) begin
            in_ok = (in_col <= CW'(GRID_N + 1)) && (in_row <= CW'(GRID_N + 1));
        end else begin
            in_ok = (in_col != '0) && (in_col <= CW'(GRID_N))
                 && (in_row != '0) && (in_row <= CW'(GRID_N));
        end
    end

    // stage 1: capture, velocity magnitudes
    t_kind            r1_kind;
    logic [CW-1:0]    r1_col, r1_row;
    logic [VAL_W-1:0] r1_val, r1_mx, r1_my;
    logic             r1_nx, r1_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= s_axis_tvalid && in_ok;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_kind <= in_kind;
            r1_col  <= in_col;
            r1_row  <= in_row;
            r1_val  <= in_val;
            r1_nx   <= in_vx[VAL_W-1];
            r1_ny   <= in_vy[VAL_W-1];
            r1_mx   <= in_vx[VAL_W-1] ? (~in_vx + 1'b1) : in_vx;
            r1_my   <= in_vy[VAL_W-1] ? (~in_vy + 1'b1) : in_vy;
        end
    end

    // stage 2: time_step * |velocity|
    t_kind            r2_kind;
    logic [CW-1:0]    r2_col, r2_row;
    logic [VAL_W-1:0] r2_val;
    logic             r2_nx, r2_ny;
    logic [63:0]      r2_px, r2_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_kind <= r1_kind;
            r2_col  <= r1_col;
            r2_row  <= r1_row;
            r2_val  <= r1_val;
            r2_nx   <= r1_nx;
            r2_ny   <= r1_ny;
            r2_px   <= {32'd0, r_time_step} * {32'd0, r1_mx};
            r2_py   <= {32'd0, r_time_step} * {32'd0, r1_my};
        end
    end

    // stage 3: scale by GRID_N; far-out products only flag a clamp
    t_kind            r3_kind;
    logic [CW-1:0]    r3_col, r3_row;
    logic [VAL_W-1:0] r3_val;
    logic             r3_nx, r3_ny, r3_bx, r3_by;
    logic [MW-1:0]    r3_mx, r3_my;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_kind <= r2_kind;
            r3_col  <= r2_col;
            r3_row  <= r2_row;
            r3_val  <= r2_val;
            r3_nx   <= r2_nx;
            r3_ny   <= r2_ny;
            r3_bx   <= |r2_px[63:PW];
            r3_by   <= |r2_py[63:PW];
            r3_mx   <= {NW'(0), r2_px[PW-1:0]} * MW'(GRID_N);
            r3_my   <= {NW'(0), r2_py[PW-1:0]} * MW'(GRID_N);
        end
    end

    // stage 4: departure point and clamp
    function automatic logic [DW-1:0] trace(input logic [CW-1:0] pos, input logic neg,
                                            input logic big, input logic [MW-1:0] m);
        logic              far;
        logic [DW-1:0]     disp;
        logic signed [DW+1:0] x;
        far  = big || (|m[MW-1:DW+FRAC_W]);
        disp = m[DW+FRAC_W-1:FRAC_W];
        if (neg) begin
            x = $signed({2'b00, pos, FRAC_W'(0)}) + $signed({2'b00, disp});
        end else begin
            x = $signed({2'b00, pos, FRAC_W'(0)}) - $signed({2'b00, disp});
        end
        if (far) begin
            trace = neg ? X_HI : X_LO;
        end else if (x < $signed({2'b00, X_LO})) begin
            trace = X_LO;
        end else if (x > $signed({2'b00, X_HI})) begin
            trace = X_HI;
        end else begin
            trace = x[DW-1:0];
        end
    endfunction

    t_kind            r4_kind;
    logic [CW-1:0]    r4_col, r4_row;
    logic [VAL_W-1:0] r4_val;
    logic [DW-1:0]    r4_x, r4_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en4) begin
            r4_v <= r3_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_kind <= r3_kind;
            r4_col  <= r3_col;
            r4_row  <= r3_row;
            r4_val  <= r3_val;
            r4_x    <= trace(r3_col, r3_nx, r3_bx, r3_mx);
            r4_y    <= trace(r3_row, r3_ny, r3_by, r3_my);
        end
    end

    // stage 5: banked grid access and bilinear weights
    logic [CW-1:0]     ui0, uj0;
    logic [FRAC_W:0]   s1, s0, t1, t0;
    logic [CW-1:0]     csel [2];
    logic [CW-1:0]     rsel [2];
    logic [AW-1:0]     rd_addr [4];
    logic [AW-1:0]     wr_addr;
    logic [VAL_W-1:0]  bank_q [4];
    logic              wr_go;
    assign ui0 = r4_x[DW-1:FRAC_W];
    assign uj0 = r4_y[DW-1:FRAC_W];
    assign s1  = {1'b0, r4_x[FRAC_W-1:0]};
    assign t1  = {1'b0, r4_y[FRAC_W-1:0]};
    assign s0  = ONE_Q - s1;
    assign t0  = ONE_Q - t1;
    assign wr_go   = en5 && r4_v && (r4_kind == KIND_LOAD);
    assign wr_addr = AW'(r4_col >> 1) + AW'(HALF) * AW'(r4_row >> 1);

    // each bank holds one (column, row) parity pair
    for (genvar p = 0; p < 2; p++) begin : g_sel
        assign csel[p] = (ui0[0] == 1'(p)) ? ui0 : ui0 + 1'b1;
        assign rsel[p] = (uj0[0] == 1'(p)) ? uj0 : uj0 + 1'b1;
    end
    for (genvar b = 0; b < 4; b++) begin : g_bank
        assign rd_addr[b] = AW'(csel[b % 2] >> 1) + AW'(HALF) * AW'(rsel[b / 2] >> 1);
        sla_bank #(
            .AW    (AW),
            .DEPTH (DEPTH)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (wr_go && (r4_col[0] == 1'(b % 2)) && (r4_row[0] == 1'(b / 2))),
            .i_wr_addr (wr_addr),
            .i_wr_data (r4_val),
            .i_rd_en   (en5),
            .i_rd_addr (rd_addr[b]),
            .o_rd_data (bank_q[b])
        );
    end

    logic [CW-1:0] r5_col, r5_row;
    logic          r5_xp, r5_yp;
    logic [WW-1:0] r5_w00, r5_w10, r5_w01, r5_w11;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en5) begin
            r5_v <= r4_v && (r4_kind == KIND_ADVECT);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_col <= r4_col;
            r5_row <= r4_row;
            r5_xp  <= ui0[0];
            r5_yp  <= uj0[0];
            r5_w00 <= WW'({{(WW-FRAC_W-1){1'b0}}, s0} * {{(WW-FRAC_W-1){1'b0}}, t0});
            r5_w10 <= WW'({{(WW-FRAC_W-1){1'b0}}, s1} * {{(WW-FRAC_W-1){1'b0}}, t0});
            r5_w01 <= WW'({{(WW-FRAC_W-1){1'b0}}, s0} * {{(WW-FRAC_W-1){1'b0}}, t1});
            r5_w11 <= WW'({{(WW-FRAC_W-1){1'b0}}, s1} * {{(WW-FRAC_W-1){1'b0}}, t1});
        end
    end

    // stage 6: weighted corner products
    logic [VAL_W-1:0] a00, a10, a01, a11;
    assign a00 = bank_q[{r5_yp, r5_xp}];
    assign a10 = bank_q[{r5_yp, ~r5_xp}];
    assign a01 = bank_q[{~r5_yp, r5_xp}];
    assign a11 = bank_q[{~r5_yp, ~r5_xp}];

    logic [CW-1:0]                r6_col, r6_row;
    logic signed [WW+VAL_W:0]     r6_p00, r6_p10, r6_p01, r6_p11;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en6) begin
            r6_v <= r5_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_col <= r5_col;
            r6_row <= r5_row;
            r6_p00 <= $signed({1'b0, r5_w00}) * $signed(a00);
            r6_p10 <= $signed({1'b0, r5_w10}) * $signed(a10);
            r6_p01 <= $signed({1'b0, r5_w01}) * $signed(a01);
            r6_p11 <= $signed({1'b0, r5_w11}) * $signed(a11);
        end
    end

    // stage 7: pair sums
    logic [CW-1:0]              r7_col, r7_row;
    logic signed [WW+VAL_W+1:0] r7_sl, r7_sr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en7) begin
            r7_v <= r6_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_col <= r6_col;
            r7_row <= r6_row;
            r7_sl  <= (WW+VAL_W+2)'(r6_p00) + (WW+VAL_W+2)'(r6_p01);
            r7_sr  <= (WW+VAL_W+2)'(r6_p10) + (WW+VAL_W+2)'(r6_p11);
        end
    end

    // stage 8: total, round half up to Q16.16
    logic signed [WW+VAL_W+2:0] sum, rnd;
    assign sum = (WW+VAL_W+3)'(r7_sl) + (WW+VAL_W+3)'(r7_sr);
    assign rnd = (sum + $signed((WW+VAL_W+3)'(64'h8000_0000))) >>> (2 * FRAC_W);

    logic [CW-1:0]    r8_col, r8_row;
    logic [VAL_W-1:0] r8_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en8) begin
            r8_v <= r7_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en8) begin
            r8_col <= r7_col;
            r8_row <= r7_row;
            r8_val <= rnd[VAL_W-1:0];
        end
    end

    assign m_axis_tvalid = r8_v;
    assign m_axis_tdata  = TDW_O'({r8_val, r8_row, r8_col});

    // checks
    `SLA_ASSERT_NOW(a_out_interior, i_clk, i_rst_n, r8_v,
        (r8_col != '0) && (r8_col <= CW'(GRID_N)) && (r8_row != '0) && (r8_row <= CW'(GRID_N)))
    `SLA_ASSERT_NOW(a_empty_out_ready, i_clk, i_rst_n, !r8_v, s_axis_tready)
    `SLA_ASSERT_NOW(a_departure_clamped, i_clk, i_rst_n, r4_v && (r4_kind == KIND_ADVECT),
        (r4_x >= X_LO) && (r4_x <= X_HI) && (r4_y >= X_LO) && (r4_y <= X_HI))
    `SLA_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n, r8_v && !m_axis_tready,
        r8_v && $stable(r8_val))
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the semi-Lagrangian advection unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import sla_pkg::*;

    localparam int GN         = 64;
    localparam int SIDE       = GN + 2;
    localparam int CELLS      = SIDE * SIDE;
    localparam int PIPE_DRAIN = 20;
    localparam int CYCLE_CAP  = 50000;
    localparam int RAND_ITEMS = 80;

    // Result expected from one advect transaction
    typedef struct {
        logic [6:0]  col;
        logic [6:0]  row;
        logic [31:0] value;
    } t_advection;

    // One row of the directed stimulus table
    typedef struct {
        t_kind       kind;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [31:0] value;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        bit          typed;
        logic [31:0] typed_value;
    } t_vector;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_valid   = 1'b0;
    logic          o_cfg_ready;
    logic [31:0]   i_cfg_data    = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [111:0]  s_axis_tdata  = '0;  // col, row, cell_value, vel_x, vel_y
    logic          s_axis_tuser  = 1'b0; // kind
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [47:0]   m_axis_tdata;         // out_col, out_row, advected_value

    // Shadow of the block state
    logic [31:0]   grid_shadow [CELLS];
    bit            loaded [CELLS];
    logic [31:0]   step_shadow;
    t_advection    pending_advections [$];

    int unsigned   cycle_count = 0;
    int unsigned   error_count = 0;
    int unsigned   result_count = 0;
    int unsigned   advect_count = 0;
    int unsigned   load_count = 0;

    semi_lagrangian_advection_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One long stretch without any idling on either side
    function automatic bit calm_window();
        return (cycle_count >= 600) && (cycle_count < 900);
    endfunction

    // Departure coordinate in Q16.16, clamped to [0.5, N+0.5]
    function automatic longint departure(int pos, logic [63:0] h, logic [31:0] vel);
        logic [31:0] mag32;
        logic [63:0] mag;
        logic [63:0] disp;
        longint      x;
        mag32 = vel[31] ? -vel : vel;
        mag   = {32'd0, mag32};
        disp  = (((h >> 21) * mag) << 5) + (((h & 64'h1F_FFFF) * mag) >> 16);
        x     = longint'(pos) <<< 16;
        x     = vel[31] ? x + longint'(disp) : x - longint'(disp);
        if (x < 64'sh8000) x = 64'sh8000;
        if (x > longint'(GN) * 65536 + 32768) x = longint'(GN) * 65536 + 32768;
        return x;
    endfunction

    function automatic longint cell_at(int c, int r);
        return longint'($signed(grid_shadow[c + SIDE * r]));
    endfunction

    // Bilinear interpolation of the traced-back point
    function automatic logic [31:0] advect_value(int col, int row,
                                                 logic [31:0] vx, logic [31:0] vy);
        logic [63:0] h;
        logic [63:0] shifted;
        longint      x, y, s1, s0, t1, t0, left, right, sum;
        int          ci, rj;
        h     = {32'd0, step_shadow} * GN;
        x     = departure(col, h, vx);
        y     = departure(row, h, vy);
        ci    = int'(x >>> 16);
        rj    = int'(y >>> 16);
        s1    = x & 64'hFFFF;
        s0    = 65536 - s1;
        t1    = y & 64'hFFFF;
        t0    = 65536 - t1;
        left  = t0 * cell_at(ci, rj) + t1 * cell_at(ci, rj + 1);
        right = t0 * cell_at(ci + 1, rj) + t1 * cell_at(ci + 1, rj + 1);
        sum   = s0 * left + s1 * right;
        // round half up: floor((sum + 2^31) / 2^32) via offset binary
        shifted = ((64'(sum) ^ 64'h8000_0000_0000_0000) + 64'h8000_0000) >> 32;
        return shifted[31:0] ^ 32'h8000_0000;
    endfunction

    // Drive one item, wait for its transaction, then update the shadow
    task automatic send_item(t_kind kind, logic [6:0] col, logic [6:0] row,
                             logic [31:0] value, logic [31:0] vx, logic [31:0] vy,
                             bit typed, logic [31:0] typed_value);
        t_advection adv;
        // the four cells an interior advect reads are loaded first
        if (kind == KIND_ADVECT && col >= 1 && col <= GN && row >= 1 && row <= GN)
            fill_corners(col, row, vx, vy);
        if (!calm_window() && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, vy, vx, value, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_LOAD) begin
            load_count++;
            if (col <= GN + 1 && row <= GN + 1) begin
                grid_shadow[col + SIDE * row] = value;
                loaded[col + SIDE * row]      = 1'b1;
            end
        end else if (col >= 1 && col <= GN && row >= 1 && row <= GN) begin
            advect_count++;
            adv.col   = col;
            adv.row   = row;
            adv.value = typed ? typed_value : advect_value(col, row, vx, vy);
            pending_advections.push_back(adv);
        end
    endtask

    // Load any of the four corner cells of the departure point not yet written
    task automatic fill_corners(logic [6:0] col, logic [6:0] row,
                                logic [31:0] vx, logic [31:0] vy);
        logic [63:0] h;
        int          ci, rj, c, r;
        h  = {32'd0, step_shadow} * GN;
        ci = int'(departure(int'(col), h, vx) >>> 16);
        rj = int'(departure(int'(row), h, vy) >>> 16);
        for (int k = 0; k < 4; k++) begin
            c = ci + k % 2;
            r = rj + k / 2;
            if (!loaded[c + SIDE * r])
                send_item(KIND_LOAD, 7'(c), 7'(r), $urandom, '0, '0, 1'b0, '0);
        end
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until every advect result is back, then let the pipe drain
    task automatic wait_drained();
        while (pending_advections.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_time_step(logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        step_shadow = value;
    endtask

    function automatic logic [31:0] random_velocity();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(65536 * 4) - 32'd131072;
            default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Mostly interior advects and in-grid loads, some out-of-range noise
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            send_item(KIND_ADVECT, 7'($urandom_range(1, GN)), 7'($urandom_range(1, GN)),
                      $urandom, random_velocity(), random_velocity(), 1'b0, '0);
        else if (pick < 85)
            send_item(KIND_LOAD, 7'($urandom_range(GN + 1)), 7'($urandom_range(GN + 1)),
                      $urandom, $urandom, $urandom, 1'b0, '0);
        else
            send_item(t_kind'($urandom_range(1)), 7'($urandom_range(127)),
                      7'($urandom_range(127)), $urandom, $urandom, $urandom, 1'b0, '0);
    endtask

    // Result side: random back-pressure and checking
    always @(posedge i_clk) begin
        t_advection want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count <= result_count + 1;
            if (pending_advections.size() == 0) begin
                $error("result with no advect outstanding: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_advections.pop_front();
                if (m_axis_tdata[6:0] !== want.col) begin
                    $error("out_col expected %0d actual %0d", want.col, m_axis_tdata[6:0]);
                    error_count++;
                end
                if (m_axis_tdata[13:7] !== want.row) begin
                    $error("out_row expected %0d actual %0d", want.row, m_axis_tdata[13:7]);
                    error_count++;
                end
                if (m_axis_tdata[45:14] !== want.value) begin
                    $error("advected_value expected %h actual %h", want.value,
                           m_axis_tdata[45:14]);
                    error_count++;
                end
            end
        end
        m_axis_tready <= calm_window() || ($urandom_range(99) >= 24);
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout at cycle %0d, %0d results outstanding", cycle_count,
                     pending_advections.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    t_vector directed [] = '{
        // exact cell read with zero velocity, both value extremes
        '{KIND_LOAD,   7'd5,   7'd5,  32'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd5,   7'd5,  '0, '0, '0, 1'b1, 32'h7FFF_FFFF},
        '{KIND_LOAD,   7'd6,   7'd6,  32'h8000_0000, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd6,   7'd6,  '0, '0, '0, 1'b1, 32'h8000_0000},
        // clamp to the low corner over zeroed cells
        '{KIND_LOAD,   7'd0,   7'd0,  '0, '0, '0, 1'b0, '0},
        '{KIND_LOAD,   7'd1,   7'd0,  '0, '0, '0, 1'b0, '0},
        '{KIND_LOAD,   7'd0,   7'd1,  '0, '0, '0, 1'b0, '0},
        '{KIND_LOAD,   7'd1,   7'd1,  '0, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd1,   7'd1,  '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '0},
        // clamp to the high corner, most negative velocity
        '{KIND_LOAD,   7'd65,  7'd65, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd64,  7'd64, '0, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
        '{KIND_ADVECT, 7'd1,   7'd64, '0, 32'h0001_8000, 32'hFFFE_8000, 1'b0, '0},
        '{KIND_ADVECT, 7'd64,  7'd1,  '0, 32'hFFFF_0001, 32'h0000_FFFF, 1'b0, '0},
        // advect outside the interior gives nothing
        '{KIND_ADVECT, 7'd0,   7'd10, '0, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd65,  7'd10, '0, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd10,  7'd0,  '0, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd10,  7'd65, '0, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd127, 7'd127, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        // loads outside the grid are dropped
        '{KIND_LOAD,   7'd127, 7'd3,  32'h1234_5678, '0, '0, 1'b0, '0},
        '{KIND_LOAD,   7'd3,   7'd66, 32'h1234_5678, '0, '0, 1'b0, '0},
        '{KIND_ADVECT, 7'd3,   7'd3,  '0, 32'h0000_4000, 32'hFFFF_C000, 1'b0, '0}
    };

    logic [31:0] step_settings [5] = '{32'd0, 32'hFFFF_FFFF, 32'd65536, 32'd6554, 32'd0};

    initial begin
        step_shadow = TIME_STEP_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cells are loaded on demand before any advect reads them
        foreach (directed[k])
            send_item(directed[k].kind, directed[k].col, directed[k].row, directed[k].value,
                      directed[k].vel_x, directed[k].vel_y, directed[k].typed,
                      directed[k].typed_value);
        stop_sending();
        wait_drained();

        step_settings[4] = $urandom;
        foreach (step_settings[p]) begin
            write_time_step(step_settings[p]);
            repeat (RAND_ITEMS) random_item();
            stop_sending();
            wait_drained();
        end

        $display("covered %0d loads and %0d interior advects over %0d time steps,",
                 load_count, advect_count, $size(step_settings) + 1);
        $display("%0d results checked in %0d cycles", result_count, cycle_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+design
design/sla_pkg.sv
design/sla_bank.sv
design/semi_lagrangian_advection_unit.sv
tb/testbench.sv
